FILE: rtl/olnu_pkg.sv
// package for the online logistic neuron update block
// types, constants and the sigmoid base table; no dependencies
`timescale 1ns / 1ps
package olnu_pkg;

  // segment count stays a power of two so segment bounds and interpolation are shifts
  localparam int SigmoidSegments = 16;
  localparam int SegShift = 20 - $clog2(SigmoidSegments);
  localparam int DefWeightBits = 24;
  localparam logic [15:0] LrReset = 16'd6554;
  localparam logic [15:0] TargetReset = 16'd52429;
  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam int CfgAddrBits = 3;
  localparam logic [CfgAddrBits-1:0] AddrLearningRate = 3'd0;
  localparam logic [CfgAddrBits-1:0] AddrTargetDifficulty = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_HIT,
    ST_DIV_ENEMY,
    ST_MUL_HIT,
    ST_MUL_ENEMY,
    ST_CLAMP,
    ST_SEG,
    ST_INTERP,
    ST_ERR,
    ST_SCALE,
    ST_UPD_HIT,
    ST_UPD_ENEMY,
    ST_OUT
  } olnu_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_enemy;
    logic mul_hit;
    logic mul_enemy;
    logic clamp;
    logic seg;
    logic interp;
    logic err;
    logic scale;
    logic upd_hit;
    logic upd_enemy;
    logic out_load;
  } olnu_cmd_t;

  typedef struct packed {
    logic div_done;
  } olnu_stat_t;

  function automatic logic [15:0] sig_tab(input logic [5:0] i);
    case (i)
      6'd0: sig_tab = 16'd22;     6'd1: sig_tab = 16'd36;
      6'd2: sig_tab = 16'd60;     6'd3: sig_tab = 16'd98;
      6'd4: sig_tab = 16'd162;    6'd5: sig_tab = 16'd267;
      6'd6: sig_tab = 16'd439;    6'd7: sig_tab = 16'd720;
      6'd8: sig_tab = 16'd1179;   6'd9: sig_tab = 16'd1921;
      6'd10: sig_tab = 16'd3108;  6'd11: sig_tab = 16'd4971;
      6'd12: sig_tab = 16'd7812;  6'd13: sig_tab = 16'd11956;
      6'd14: sig_tab = 16'd17625; 6'd15: sig_tab = 16'd24743;
      6'd16: sig_tab = 16'd32768; 6'd17: sig_tab = 16'd40793;
      6'd18: sig_tab = 16'd47911; 6'd19: sig_tab = 16'd53581;
      6'd20: sig_tab = 16'd57724; 6'd21: sig_tab = 16'd60565;
      6'd22: sig_tab = 16'd62428; 6'd23: sig_tab = 16'd63615;
      6'd24: sig_tab = 16'd64357; 6'd25: sig_tab = 16'd64816;
      6'd26: sig_tab = 16'd65097; 6'd27: sig_tab = 16'd65269;
      6'd28: sig_tab = 16'd65374; 6'd29: sig_tab = 16'd65438;
      6'd30: sig_tab = 16'd65476; 6'd31: sig_tab = 16'd65500;
      default: sig_tab = 16'd65514;
    endcase
  endfunction

  // base curve at u in [0, 16.0] measured from -8, u is 21 bits
  function automatic logic [15:0] base_curve(input logic [20:0] u);
    logic [5:0] idx;
    logic [14:0] frac;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [31:0] prod;
    idx = u[20:15];
    frac = u[14:0];
    y0 = sig_tab(idx);
    y1 = sig_tab(idx + 6'd1);
    prod = 32'(y1 - y0) * 32'(frac);
    if (idx >= 6'd32) begin
      base_curve = sig_tab(6'd32);
    end else begin
      base_curve = y0 + prod[30:15];
    end
  endfunction

endpackage

FILE: rtl/olnu_div.sv
// radix-2 restoring divider for the ratios, one quotient bit a cycle
// depends on olnu_pkg
`timescale 1ns / 1ps
module olnu_div
  import olnu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [16:0] ratio
);

  // quotient of num*2^16 / den needs 32 bits; 32 steps
  logic [31:0] quo;
  logic [16:0] rem;
  logic [15:0] dreg;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [16:0] rem_next;
  logic [31:0] quo_next;

  always_comb begin
    trial = {rem[15:0], quo[31]};
    quo_next = {quo[30:0], 1'b0};
    rem_next = trial;
    if (trial >= {1'b0, dreg}) begin
      rem_next = trial - {1'b0, dreg};
      quo_next[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        quo <= {num, 16'd0};
        rem <= '0;
        dreg <= den;
      end else if (busy) begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (dreg == 16'd0) begin
      ratio = '0;
    end else if (quo > 32'(OneQ16)) begin
      ratio = OneQ16;
    end else begin
      ratio = quo[16:0];
    end
  end

endmodule

FILE: rtl/olnu_datapath.sv
// datapath: ratios, weighted sum, sigmoid, weight update
// depends on olnu_pkg and olnu_div
`timescale 1ns / 1ps
module olnu_datapath
  import olnu_pkg::*;
#(
  parameter int WEIGHT_BITS = DefWeightBits
) (
  input  logic        clk,
  input  logic        rst,
  input  olnu_cmd_t   cmd,
  output olnu_stat_t  stat,
  input  logic [63:0] in_data,
  input  logic [15:0] learning_rate,
  input  logic [15:0] target_difficulty,
  output logic [15:0] prediction,
  output logic        divide_fault
);

  localparam int SegBits = $clog2(SigmoidSegments + 1);
  localparam int ProdBits = WEIGHT_BITS + 18;
  localparam int AccBits = WEIGHT_BITS + 19;
  // room for the +-8.0 clamp bounds even with narrow weights
  localparam int SumBits = (AccBits - 16 > 21) ? AccBits - 16 : 21;
  localparam logic signed [WEIGHT_BITS-1:0] WMax = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] WMin = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic signed [SumBits-1:0] Half = SumBits'(8 * 65536);

  logic [63:0] item;
  logic [16:0] r_hit;
  logic [16:0] r_enemy;
  logic        fault;
  logic signed [WEIGHT_BITS-1:0] w_hit;
  logic signed [WEIGHT_BITS-1:0] w_enemy;
  logic signed [AccBits-1:0] acc;
  logic [20:0] u;
  logic [SegBits-1:0] k;
  logic [20:0] lo;
  logic [15:0] ylo;
  logic [15:0] yhi;
  logic [15:0] pred_q;
  logic signed [16:0] err;
  logic signed [34:0] lr_err;

  logic [15:0] div_num;
  logic [15:0] div_den;
  logic [16:0] div_ratio;
  logic        div_done;

  assign div_num = cmd.div_sel_enemy ? item[47:32] : item[15:0];
  assign div_den = cmd.div_sel_enemy ? item[63:48] : item[31:16];

  olnu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .ratio (div_ratio)
  );

  assign stat.div_done = div_done;

  // the weight multiply is shared by the hit and enemy steps
  logic signed [ProdBits-1:0] wprod;
  logic signed [SumBits-1:0] sum;
  logic [SegBits-1:0] k_calc;
  logic [20:0] hi_calc;
  logic [36:0] interp_prod;
  logic [15:0] y_calc;
  logic [15:0] pred_val;
  logic signed [52:0] dprod;
  logic signed [20:0] delta;
  logic signed [WEIGHT_BITS+1:0] wsum;
  logic signed [WEIGHT_BITS-1:0] wsat;

  always_comb begin
    wprod = $signed(cmd.mul_enemy ? w_enemy : w_hit)
          * $signed({1'b0, cmd.mul_enemy ? r_enemy : r_hit});
    sum = SumBits'(acc >>> 16);
    k_calc = SegBits'(u >> SegShift);
    hi_calc = (21'(k) + 21'd1) << SegShift;
    // every segment has the same power-of-two width, so the divide is a shift
    interp_prod = 37'(yhi - ylo) * 37'(u - lo);
    y_calc = ylo + 16'(interp_prod >> SegShift);
    if (k >= SegBits'(SigmoidSegments)) begin
      pred_val = base_curve(21'h100000);
    end else begin
      pred_val = y_calc;
    end
    dprod = $signed({1'b0, cmd.upd_enemy ? r_enemy : r_hit}) * lr_err;
    delta = dprod[52:32];
    wsum = $signed(WEIGHT_BITS'(cmd.upd_enemy ? w_enemy : w_hit)) + delta;
    if (wsum > WMax) begin
      wsat = WMax;
    end else if (wsum < WMin) begin
      wsat = WMin;
    end else begin
      wsat = wsum[WEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_hit <= '0;
      w_enemy <= '0;
    end else begin
      if (cmd.upd_hit) w_hit <= wsat;
      if (cmd.upd_enemy) w_enemy <= wsat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
      fault <= (in_data[31:16] == 16'd0) || (in_data[63:48] == 16'd0);
    end
    if (div_done && !cmd.div_sel_enemy) r_hit <= div_ratio;
    if (div_done && cmd.div_sel_enemy) r_enemy <= div_ratio;
    if (cmd.mul_hit) acc <= AccBits'(wprod);
    if (cmd.mul_enemy) acc <= acc + AccBits'(wprod);
    if (cmd.clamp) begin
      if (sum <= -Half) begin
        u <= '0;
      end else if (sum >= Half) begin
        u <= 21'h100000;
      end else begin
        u <= 21'(sum + Half);
      end
    end
    if (cmd.seg) begin
      k <= k_calc;
      lo <= 21'(k_calc) << SegShift;
    end
    if (cmd.interp) begin
      ylo <= base_curve(lo);
      yhi <= base_curve(hi_calc);
    end
    if (cmd.err) begin
      pred_q <= pred_val;
      err <= $signed({1'b0, target_difficulty}) - $signed({1'b0, pred_val});
    end
    if (cmd.scale) lr_err <= $signed({1'b0, learning_rate}) * err;
    // output pair only changes when the previous beat has gone
    if (cmd.out_load) begin
      prediction <= pred_q;
      divide_fault <= fault;
    end
  end

endmodule

FILE: rtl/olnu_ctrl.sv
// controller state machine sequencing the datapath
// depends on olnu_pkg
`timescale 1ns / 1ps
module olnu_ctrl
  import olnu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       out_fire,
  input  olnu_stat_t stat,
  output olnu_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  olnu_state_t state, state_next;
  logic div_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      div_go <= 1'b0;
    end else begin
      state <= state_next;
      div_go <= (state_next != state) &&
                (state_next == ST_DIV_HIT || state_next == ST_DIV_ENEMY);
      if (state == ST_OUT) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_fire) state_next = ST_DIV_HIT;
      ST_DIV_HIT:   if (stat.div_done) state_next = ST_DIV_ENEMY;
      ST_DIV_ENEMY: if (stat.div_done) state_next = ST_MUL_HIT;
      ST_MUL_HIT:   state_next = ST_MUL_ENEMY;
      ST_MUL_ENEMY: state_next = ST_CLAMP;
      ST_CLAMP:     state_next = ST_SEG;
      ST_SEG:       state_next = ST_INTERP;
      ST_INTERP:    state_next = ST_ERR;
      ST_ERR:       state_next = ST_SCALE;
      ST_SCALE:     state_next = ST_UPD_HIT;
      ST_UPD_HIT:   state_next = ST_UPD_ENEMY;
      ST_UPD_ENEMY: state_next = ST_OUT;
      ST_OUT:       if (!out_valid || out_fire) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    cmd.div_start = div_go;
    cmd.div_sel_enemy = (state == ST_DIV_ENEMY);
    case (state)
      ST_MUL_HIT:   cmd.mul_hit = 1'b1;
      ST_MUL_ENEMY: cmd.mul_enemy = 1'b1;
      ST_CLAMP:     cmd.clamp = 1'b1;
      ST_SEG:       cmd.seg = 1'b1;
      ST_INTERP:    cmd.interp = 1'b1;
      ST_ERR:       cmd.err = 1'b1;
      ST_SCALE:     cmd.scale = 1'b1;
      ST_UPD_HIT:   cmd.upd_hit = 1'b1;
      ST_UPD_ENEMY: cmd.upd_enemy = 1'b1;
      ST_OUT:       cmd.out_load = !out_valid || out_fire;
      default:      cmd.load = in_fire;
    endcase
  end

  assign busy = (state != ST_IDLE);

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == ST_IDLE) else $error("item taken while busy");
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_HIT && stat.div_done) |=> state == ST_DIV_ENEMY)
    else $error("divide sequence broken");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_fire) |=> out_valid) else $error("result dropped");
`endif

endmodule

FILE: rtl/online_logistic_neuron_update_top.sv
// channel  dir  width  fields (low bit up)
// s_axis   in   64     hit_count, shot_count, enemies_left, enemies_total
// m_axis   out  16+1   prediction in tdata, divide_fault in tuser
// apb      in   32     learning_rate @0, target_difficulty @4
// when results are taken at once, one item runs two 32-step serial divisions,
// ten sequencer steps and a return to idle before the next beat
// one item in flight at a time
// rst is synchronous, clears weights and sets the config registers to defaults
// a result held by m_axis_tready low stalls the next item in its last step
`timescale 1ns / 1ps
module online_logistic_neuron_update_top
  import olnu_pkg::*;
#(
  parameter int WEIGHT_BITS = DefWeightBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // hit_count, shot_count, enemies_left, enemies_total
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // prediction
  output logic        m_axis_tuser,  // divide_fault
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] learning_rate;
  logic [15:0] target_difficulty;
  olnu_cmd_t cmd;
  olnu_stat_t stat;
  logic busy;
  logic in_fire;

  assign pready = 1'b1;
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LrReset;
      target_difficulty <= TargetReset;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrLearningRate:     learning_rate <= pwdata[15:0];
        AddrTargetDifficulty: target_difficulty <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrLearningRate:     prdata = {16'd0, learning_rate};
      AddrTargetDifficulty: prdata = {16'd0, target_difficulty};
      default:              prdata = '0;
    endcase
  end

  olnu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .out_fire  (m_axis_tvalid && m_axis_tready),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (m_axis_tvalid)
  );

  olnu_datapath #(
    .WEIGHT_BITS      (WEIGHT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_data           (s_axis_tdata),
    .learning_rate     (learning_rate),
    .target_difficulty (target_difficulty),
    .prediction        (m_axis_tdata),
    .divide_fault      (m_axis_tuser)
  );

endmodule
